### design/bil_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bounded indexed list.
// No dependencies; imported by bil_cell and bounded_indexed_list.
package bil_pkg;

   localparam int unsigned DEFAULT_LIST_DEPTH = 16;
   localparam int unsigned POS_W              = 8;
   localparam int unsigned DATA_W             = 32;

   typedef enum logic [3:0] {
      OP_INSERT       = 4'd0,
      OP_INSERT_FRONT = 4'd1,
      OP_INSERT_BACK  = 4'd2,
      OP_REMOVE       = 4'd3,
      OP_REMOVE_FRONT = 4'd4,
      OP_REMOVE_BACK  = 4'd5,
      OP_REPLACE      = 4'd6,
      OP_SELECT       = 4'd7,
      OP_SEARCH       = 4'd8
   } op_type;

   // Broadcast action for every cell in the row
   typedef enum logic [1:0] {
      CMD_NONE   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_WRITE  = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         count;
   } cell_cmd_type;

   typedef struct packed {
      logic [3:0]               op;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] read_value;
      logic [POS_W-1:0]         found_position;
      logic [POS_W-1:0]         count;
      logic                     is_empty;
      logic                     is_full;
   } rsp_payload_type;

endpackage

### design/bil_cell.sv
`timescale 1ns / 1ps
// One list slot: holds an entry, shifts with its neighbors, flags a search hit.
// Depends on bil_pkg.
module bil_cell #(
   parameter int unsigned INDEX = 0
) (
   input  logic                              clock,
   input  bil_pkg::cell_cmd_type             cmd,
   input  logic signed [bil_pkg::DATA_W-1:0] left_data,
   input  logic signed [bil_pkg::DATA_W-1:0] right_data,
   output logic signed [bil_pkg::DATA_W-1:0] entry,
   output logic                              match
);
   import bil_pkg::*;

   localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.kind)
         CMD_INSERT: begin
            if (MY_POS > cmd.pos) entry_in = left_data;
            else if (MY_POS == cmd.pos) entry_in = cmd.value;
         end
         CMD_REMOVE: begin
            if (MY_POS >= cmd.pos) entry_in = right_data;
         end
         CMD_WRITE: begin
            if (MY_POS == cmd.pos) entry_in = cmd.value;
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   // only live slots may hit
   assign match = (entry_ff == cmd.value) && (MY_POS < cmd.count);

endmodule

### design/bounded_indexed_list.sv
`timescale 1ns / 1ps
// Bounded indexed list: top level with op decode, cell row and result register.
// Depends on bil_pkg and bil_cell.
//
// Usage:
//   req_*  : one operation per transaction (op, position, value), valid/ready.
//   rsp_*  : one result per transaction (ok, read_value, found_position,
//            count, is_empty, is_full), valid/ready.
//   On the accepting edge the row of LIST_DEPTH cells shifts, writes and
//   compares in parallel, and the result is loaded into the output register
//   on that same edge.
//   Throughput is one transaction per cycle while the receiver takes results;
//   req_ready is high whenever the output register is empty or being drained.
//   If the receiver stalls, the result holds in the output register and
//   req_ready drops until it is taken; the list state does not change.
//   Reset clears the entry count and the output valid; entry contents are
//   left as they are and are never read before being written.
module bounded_indexed_list #(
   parameter int unsigned LIST_DEPTH = bil_pkg::DEFAULT_LIST_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bil_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bil_pkg::rsp_payload_type rsp_payload
);
   import bil_pkg::*;

   localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
   localparam int unsigned IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam logic [CW-1:0]    DEPTH_C = CW'(LIST_DEPTH);

   logic [CW-1:0]    count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;

   logic signed [DATA_W-1:0] cell_q [LIST_DEPTH];
   logic [LIST_DEPTH-1:0]    hit;
   cell_cmd_type             cmd;

   logic             accept;
   logic [POS_W-1:0] count8, pos_eff, sel_pos;
   logic             full, empty, ok;
   cmd_kind_type     kind;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign count8    = POS_W'(count_ff);
   assign full      = (count_ff == DEPTH_C);
   assign empty     = (count_ff == '0);

   always_comb begin
      pos_eff = req_payload.position;
      ok      = 1'b0;
      kind    = CMD_NONE;
      case (req_payload.op)
         OP_INSERT, OP_INSERT_FRONT, OP_INSERT_BACK: begin
            if (req_payload.op == OP_INSERT_FRONT) pos_eff = '0;
            else if (req_payload.op == OP_INSERT_BACK) pos_eff = count8;
            ok   = !full && (pos_eff <= count8);
            kind = CMD_INSERT;
         end
         OP_REMOVE, OP_REMOVE_FRONT, OP_REMOVE_BACK: begin
            if (req_payload.op == OP_REMOVE_FRONT) pos_eff = '0;
            else if (req_payload.op == OP_REMOVE_BACK) pos_eff = count8 - POS_W'(1);
            ok   = !empty && (pos_eff < count8);
            kind = CMD_REMOVE;
         end
         OP_REPLACE: begin
            ok   = (pos_eff < count8);
            kind = CMD_WRITE;
         end
         OP_SELECT, OP_SEARCH: ok = 1'b1;
         default: ok = 1'b0;
      endcase
   end

   always_comb begin
      cmd.kind  = (accept && ok) ? kind : CMD_NONE;
      cmd.pos   = pos_eff;
      cmd.value = req_payload.value;
      cmd.count = count8;
   end

   // cell row
   for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
      logic signed [DATA_W-1:0] left_d, right_d;
      if (g == 0) begin : g_first
         assign left_d = req_payload.value;
      end else begin : g_mid
         assign left_d = cell_q[g-1];
      end
      if (g == LIST_DEPTH - 1) begin : g_last
         assign right_d = cell_q[g];
      end else begin : g_inner
         assign right_d = cell_q[g+1];
      end
      bil_cell #(.INDEX(g)) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_d),
         .right_data (right_d),
         .entry      (cell_q[g]),
         .match      (hit[g])
      );
   end

   always_comb begin
      sel_pos = (req_payload.position >= count8) ? (count8 - POS_W'(1))
                                                 : req_payload.position;

      rsp_in                = '0;
      rsp_in.ok             = ok;
      count_in              = count_ff;
      if (accept && ok && kind == CMD_INSERT) count_in = count_ff + CW'(1);
      if (accept && ok && kind == CMD_REMOVE) count_in = count_ff - CW'(1);

      if (req_payload.op == OP_SELECT && !empty) begin
         rsp_in.read_value = cell_q[sel_pos[IW-1:0]];
      end
      if (req_payload.op == OP_SEARCH) begin
         // priority: lowest hit wins
         rsp_in.found_position = count8;
         for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
            if (hit[i]) rsp_in.found_position = POS_W'(i);
         end
      end
      rsp_in.count    = POS_W'(count_in);
      rsp_in.is_empty = (count_in == '0);
      rsp_in.is_full  = (count_in == DEPTH_C);

      rsp_valid_in = rsp_valid_ff;
      if (accept) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above list depth");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff))
      else $error("entry count moved without a transaction");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && (rsp_ff.count == POS_W'(count_ff)))
      else $error("reported count differs from stored count");

   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.is_empty && rsp_ff.is_full))
      else $error("empty and full reported together");

endmodule

### bench/bounded_indexed_list_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for bounded_indexed_list: directed and random list operations.
// Depends on bil_pkg and the bounded_indexed_list RTL.
module bounded_indexed_list_tb;
   import bil_pkg::*;

   localparam int unsigned LIST_DEPTH   = DEFAULT_LIST_DEPTH;
   localparam logic [3:0]  OP_UNUSED_LO = 4'd9;
   localparam logic [3:0]  OP_UNUSED_HI = 4'd15;
   localparam int          RANDOM_OPS   = 1950;

   typedef struct {
      req_payload_type payload;
      bit              drain_first;   // hold off until all results are back
   } list_op_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   list_op_type     op_queue[$];
   rsp_payload_type results_due[$];
   logic signed [DATA_W-1:0] list_entries[LIST_DEPTH];
   int unsigned     list_len = 0;
   int              mismatch_count = 0;
   int              ops_accepted = 0;
   int              ops_total = 0;
   bit              req_taken = 1'b0;
   bit              quiet_phase = 1'b0;
   int              send_gap = 0;
   int              hold_left = 0;

   bounded_indexed_list u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic bit place_value(int unsigned at, logic signed [DATA_W-1:0] v);
      if (list_len >= LIST_DEPTH || at > list_len) return 1'b0;
      for (int i = list_len; i > at; i--) list_entries[i] = list_entries[i-1];
      list_entries[at] = v;
      list_len++;
      return 1'b1;
   endfunction

   function automatic bit drop_entry(int unsigned at);
      if (at >= list_len) return 1'b0;
      for (int i = at; i + 1 < list_len; i++) list_entries[i] = list_entries[i+1];
      list_len--;
      return 1'b1;
   endfunction

   function automatic rsp_payload_type apply_list_op(req_payload_type r);
      rsp_payload_type res;
      int unsigned     at;
      bit              hit;
      res = '0;
      at  = 32'(r.position);
      hit = 1'b0;
      case (r.op)
         OP_INSERT:       res.ok = place_value(at, r.value);
         OP_INSERT_FRONT: res.ok = place_value(0, r.value);
         OP_INSERT_BACK:  res.ok = place_value(list_len, r.value);
         OP_REMOVE:       res.ok = drop_entry(at);
         OP_REMOVE_FRONT: res.ok = drop_entry(0);
         OP_REMOVE_BACK: begin
            if (list_len != 0) res.ok = drop_entry(list_len - 1);
         end
         OP_REPLACE: begin
            if (at < list_len) begin
               list_entries[at] = r.value;
               res.ok = 1'b1;
            end
         end
         OP_SELECT: begin
            res.ok = 1'b1;
            if (list_len != 0) begin
               if (at >= list_len) at = list_len - 1;
               res.read_value = list_entries[at];
            end
         end
         OP_SEARCH: begin
            res.ok = 1'b1;
            res.found_position = POS_W'(list_len);
            for (int i = 0; i < list_len; i++) begin
               if (!hit && list_entries[i] == r.value) begin
                  res.found_position = POS_W'(i);
                  hit = 1'b1;
               end
            end
         end
         default: ;
      endcase
      res.count    = POS_W'(list_len);
      res.is_empty = (list_len == 0);
      res.is_full  = (list_len == LIST_DEPTH);
      return res;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      mismatch_count++;
      $display("%0t: %s mismatch: got %h want %h", $realtime, what, got, want);
   endtask

   task automatic check_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (results_due.size() == 0) begin
         report_mismatch("unexpected transaction", DATA_W'(got.count), '0);
      end else begin
         want = results_due.pop_front();
         if (got.ok !== want.ok)
            report_mismatch("ok", DATA_W'(got.ok), DATA_W'(want.ok));
         if (got.read_value !== want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
         if (got.found_position !== want.found_position)
            report_mismatch("found_position", DATA_W'(got.found_position),
                            DATA_W'(want.found_position));
         if (got.count !== want.count)
            report_mismatch("count", DATA_W'(got.count), DATA_W'(want.count));
         if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", DATA_W'(got.is_empty), DATA_W'(want.is_empty));
         if (got.is_full !== want.is_full)
            report_mismatch("is_full", DATA_W'(got.is_full), DATA_W'(want.is_full));
      end
   endtask

   // monitor: results checked before the accepted request updates the list
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_payload);
         if (req_valid && req_ready) begin
            results_due.push_back(apply_list_op(req_payload));
            ops_accepted++;
         end
         req_taken <= req_valid && req_ready;
      end
   end

   // ---------------------------------------------------------------- driver
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_phase || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   always @(negedge clock) begin
      list_op_type nxt;
      if (!reset) begin
         if ($urandom_range(0, 399) == 0) quiet_phase = ~quiet_phase;
         // current transaction still pending: keep valid and payload as they are
         if (!(req_valid && !req_taken)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (op_queue.size() == 0) begin
               req_valid <= 1'b0;
            end else if (op_queue[0].drain_first && results_due.size() != 0) begin
               req_valid <= 1'b0;
            end else begin
               nxt = op_queue.pop_front();
               req_payload <= nxt.payload;
               req_valid   <= 1'b1;
               send_gap = pick_gap();
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) hold_left = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   task automatic add_op(input logic [3:0] op, input logic [POS_W-1:0] pos,
                         input logic signed [DATA_W-1:0] val, input bit drain = 1'b0);
      list_op_type item;
      item.payload.op       = op;
      item.payload.position = pos;
      item.payload.value    = val;
      item.drain_first      = drain;
      op_queue.push_back(item);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      // a small pool gives searches something to find
      case ($urandom_range(0, 9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return -32'sd1;
         3, 4, 5: return $urandom_range(0, 5);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return POS_W'($urandom_range(0, LIST_DEPTH + 1));
      if (r < 9) return POS_W'($urandom_range(0, 3));
      return POS_W'($urandom_range(0, 255));
   endfunction

   // mode 0 grows the list, 1 shrinks it, 2 mixes everything
   function automatic logic [3:0] pick_op(int mode);
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) return 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      if (mode == 0 && r < 70 || mode == 1 && r < 15) begin
         case ($urandom_range(0, 2))
            0:       return OP_INSERT;
            1:       return OP_INSERT_FRONT;
            default: return OP_INSERT_BACK;
         endcase
      end
      if (mode == 1 && r < 70 || mode == 0 && r < 80) begin
         case ($urandom_range(0, 2))
            0:       return OP_REMOVE;
            1:       return OP_REMOVE_FRONT;
            default: return OP_REMOVE_BACK;
         endcase
      end
      case ($urandom_range(0, 6))
         0:       return OP_INSERT;
         1:       return OP_REMOVE;
         2, 3:    return OP_REPLACE;
         4:       return OP_SELECT;
         default: return OP_SEARCH;
      endcase
   endfunction

   initial begin
      int         mode;
      int         seg_left;
      int         made;
      logic [3:0] op;

      // empty-list corner cases and unused codes
      add_op(OP_SEARCH,       8'd0,   32'sd0);
      add_op(OP_SELECT,       8'd255, 32'sd0);
      add_op(OP_REMOVE_FRONT, 8'd0,   32'sd0);
      add_op(OP_REMOVE_BACK,  8'd0,   32'sd0);
      add_op(OP_REMOVE,       8'd0,   32'sd0);
      add_op(OP_REPLACE,      8'd0,   32'sd5);
      add_op(OP_INSERT,       8'd1,   32'sd7);
      add_op(OP_UNUSED_LO,    8'd0,   32'sd0);
      // build a short list with extreme values
      add_op(OP_INSERT,       8'd0,   32'sh8000_0000);
      add_op(OP_INSERT_BACK,  8'd200, 32'sh7fff_ffff);
      add_op(OP_INSERT_FRONT, 8'd0,   -32'sd1);
      add_op(OP_INSERT,       8'd3,   32'sd0);    // position equal to count appends
      add_op(OP_INSERT,       8'd1,   32'sh5555_aaaa);
      add_op(OP_INSERT,       8'd9,   32'sd1);    // beyond count
      add_op(OP_SELECT,       8'd255, 32'sd0);    // clamps to last entry
      add_op(OP_SELECT,       8'd0,   32'sd0);
      add_op(OP_SEARCH,       8'd0,   32'sh7fff_ffff);
      add_op(OP_SEARCH,       8'd0,   32'sd12345);
      add_op(OP_REPLACE,      8'd1,   32'shffff_0000);
      add_op(OP_REPLACE,      8'd5,   32'sd3);    // position equal to count
      add_op(OP_REMOVE,       8'd2,   32'sd0);
      add_op(OP_REMOVE,       8'd4,   32'sd0);    // position equal to count
      add_op(OP_REMOVE_BACK,  8'd0,   32'sd0);
      add_op(OP_REMOVE_FRONT, 8'd0,   32'sd0);
      add_op(OP_UNUSED_HI,    8'd255, 32'shffff_ffff);

      made = 0;
      seg_left = 0;
      mode = 0;
      while (made < RANDOM_OPS) begin
         if (seg_left == 0) begin
            mode = $urandom_range(0, 2);
            seg_left = $urandom_range(10, 60);
         end
         op = pick_op(mode);
         add_op(op, pick_position(), pick_value(),
                made == 0 || $urandom_range(0, 199) == 0);
         if (op <= OP_SEARCH) made++;
         seg_left--;
      end
      ops_total = op_queue.size();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (ops_accepted < ops_total) @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### bounded_indexed_list.f
design/bil_pkg.sv
design/bil_cell.sv
design/bounded_indexed_list.sv
bench/bounded_indexed_list_tb.sv
